/* sv/assert_macros.svh */
// Assertion macros shared by the policer modules; they expect clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold on every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

/* sv/plcr_pkg.sv */
// Shared types and constants of the per-flow loss policer.
package plcr_pkg;

	localparam logic [2:0] REQ_TX_CHECK  = 3'd0;
	localparam logic [2:0] REQ_TX_COUNT  = 3'd1;
	localparam logic [2:0] REQ_LINK_DROP = 3'd2;
	localparam logic [2:0] REQ_RX        = 3'd3;
	localparam logic [2:0] REQ_TICK      = 3'd4;

	localparam logic [2:0] CFG_EARLY_DROP = 3'd0;
	localparam logic [2:0] CFG_FAIRNESS   = 3'd1;
	localparam logic [2:0] CFG_EWMA       = 3'd2;
	localparam logic [2:0] CFG_THRESHOLD  = 3'd3;
	localparam logic [2:0] CFG_LOSS_WIN   = 3'd4;
	localparam logic [2:0] CFG_ACTIVE     = 3'd5;

	localparam logic [1:0] MODE_NATURAL = 2'd0;
	localparam logic [1:0] MODE_EQUAL   = 2'd1;

	// At or below this many sent packets a flow's estimate only decays.
	localparam int unsigned MIN_SAMPLES = 5;

	typedef enum logic [2:0] {
		K_TX_CHECK,
		K_TX_COUNT,
		K_LINK_DROP,
		K_RX,
		K_TICK,
		K_NOP
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic        ok;
		logic [5:0]  flow;
	} item_t;

	typedef struct packed {
		logic        early_en;
		logic [1:0]  mode;
		logic [15:0] weight;
		logic [15:0] threshold;
		logic [15:0] loss_win;
		logic [6:0]  n_use;
	} cfg_t;

endpackage

/* sv/plcr_front.sv */
// Front end: takes input words, classifies them and forwards them to the queue.
module plcr_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [2:0]          req_type,
	input  logic [5:0]          flow,
	input  logic [6:0]          n_use,
	output logic                push,
	output plcr_pkg::item_t     push_item,
	input  logic                q_full
);

	logic            vld_s1;
	plcr_pkg::item_t item_s1;
	plcr_pkg::item_t cls;

	always_comb begin
		cls.flow = flow;
		cls.ok   = ({1'b0, flow} < n_use);
		case (req_type)
			plcr_pkg::REQ_TX_CHECK:  cls.kind = plcr_pkg::K_TX_CHECK;
			plcr_pkg::REQ_TX_COUNT:  cls.kind = plcr_pkg::K_TX_COUNT;
			plcr_pkg::REQ_LINK_DROP: cls.kind = plcr_pkg::K_LINK_DROP;
			plcr_pkg::REQ_RX:        cls.kind = plcr_pkg::K_RX;
			plcr_pkg::REQ_TICK:      cls.kind = plcr_pkg::K_TICK;
			default:                 cls.kind = plcr_pkg::K_NOP;
		endcase
	end

	assign push      = vld_s1 && !q_full;
	assign push_item = item_s1;
	assign in_ready  = !vld_s1 || !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= cls;
		end
	end

endmodule

/* sv/plcr_fifo.sv */
// Two-entry queue between front end and back end.
`include "assert_macros.svh"
module plcr_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  plcr_pkg::item_t push_item,
	output logic            full,
	input  logic            pop,
	output logic            head_vld,
	output plcr_pkg::item_t head
);

	plcr_pkg::item_t mem_q [2];
	logic            wp_q;
	logic            rp_q;
	logic [1:0]      cnt_q;

	assign full     = (cnt_q == 2'd2);
	assign head_vld = (cnt_q != 2'd0);
	assign head     = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop) rp_q <= !rp_q;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= push_item;
	end

	`ASSERT_IMP(a_no_overflow, push, !full, "queue push while full")
	`ASSERT_IMP(a_no_underflow, pop, head_vld, "queue pop while empty")

endmodule

/* sv/plcr_div.sv */
// Restoring divider, one quotient bit per cycle.
`include "assert_macros.svh"
module plcr_div #(
	parameter int unsigned NW = 40,
	parameter int unsigned DW = 24
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [NW-1:0] quo
);

	localparam int unsigned CNTW = $clog2(NW + 1);

	logic [NW-1:0]   quo_q;
	logic [DW-1:0]   rem_q;
	logic [DW-1:0]   den_q;
	logic [CNTW-1:0] cnt_q;
	logic            busy_q;
	logic            done_q;
	logic [DW:0]     rem_sh;
	logic            ge;

	assign rem_sh = {rem_q, quo_q[NW-1]};
	assign ge     = (rem_sh >= {1'b0, den_q});
	assign done   = done_q;
	assign quo    = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNTW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNTW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			quo_q <= {quo_q[NW-2:0], ge};
			rem_q <= ge ? DW'(rem_sh - {1'b0, den_q}) : rem_sh[DW-1:0];
		end
	end

	`ASSERT_IMP(a_start_idle, start, !busy_q, "divider started while busy")

endmodule

/* sv/plcr_back.sv */
// Back end: per-flow state memory, tick sequencer and result register.
`include "assert_macros.svh"
module plcr_back #(
	parameter int unsigned NUM_FLOWS   = 8,
	parameter int unsigned COUNT_WIDTH = 24,
	parameter int unsigned FRAC_BITS   = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  plcr_pkg::cfg_t  cfg,
	input  logic            head_vld,
	input  plcr_pkg::item_t head,
	output logic            pop,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [5:0]      flow_id,
	output logic            early_drop,
	output logic [23:0]     allowed_window,
	output logic [15:0]     flow_loss,
	output logic [15:0]     shared_loss,
	output logic            last
);

	localparam int unsigned CW   = COUNT_WIDTH;
	localparam int unsigned FB   = FRAC_BITS;
	localparam int unsigned FW   = (NUM_FLOWS > 1) ? $clog2(NUM_FLOWS) : 1;
	localparam int unsigned NW   = CW + FB;
	localparam int unsigned DW   = (CW > 16) ? CW : 16;
	localparam int unsigned CAPW = CW + 7;
	localparam int unsigned MW   = (FB + 1 > 17) ? FB + 1 : 17;
	localparam int unsigned TW   = (FB > 16) ? FB : 16;
	localparam int unsigned AW   = (CW > 24) ? CW : 24;
	localparam int unsigned PW   = 2 * FB + 2;

	typedef struct packed {
		logic [CW-1:0] sent;
		logic [CW-1:0] link;
		logic [CW-1:0] pol;
		logic [CW-1:0] win;
		logic [FB-1:0] est;
	} ent_t;

	typedef enum logic [10:0] {
		S_IDLE   = 11'b00000000001,
		S_PKT    = 11'b00000000010,
		S_T1RD   = 11'b00000000100,
		S_T1CALC = 11'b00000001000,
		S_T1WAIT = 11'b00000010000,
		S_T1MUL  = 11'b00000100000,
		S_T1ACC  = 11'b00001000000,
		S_EQWAIT = 11'b00010000000,
		S_T2RD   = 11'b00100000000,
		S_T2OUT  = 11'b01000000000,
		S_RXDIV  = 11'b10000000000
	} state_t;

	function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
		return (&v) ? v : CW'(v + 1'b1);
	endfunction

	state_t          state_q;
	plcr_pkg::item_t cur_q;
	logic [6:0]      i_q;

	// state memory, registered read
	ent_t            mem [NUM_FLOWS];
	ent_t            rd_q;
	logic            rd_cv_q, rd_sv_q;
	logic [NUM_FLOWS-1:0] cnt_vld_q, st_vld_q;
	logic            rd_en, wr_en, cnt_clr;
	logic [FW-1:0]   rd_addr, wr_addr;
	ent_t            wr_data;
	ent_t            ent;

	logic [15:0]     rx_q;
	logic [CW-1:0]   drops_q;
	logic [FB-1:0]   shared_q;
	logic [CAPW-1:0] cap_q;
	logic [CW-1:0]   eq_q;
	logic [FB-1:0]   rate_q;
	logic [PW-1:0]   prod_a_q;

	logic            div_start, div_done;
	logic [NW-1:0]   div_num, div_quo;
	logic [DW-1:0]   div_den;

	logic            out_free, out_ld;
	logic [5:0]      o_flow;
	logic            o_drop, o_last;
	logic [CW-1:0]   o_win;
	logic [FB-1:0]   o_est;

	logic [MW-1:0]   w_ext, one_ext, beta_ext;
	logic [FB:0]     beta;
	logic [FB:0]     one_m_beta;
	logic [CW-1:0]   s_inc;
	logic [CW:0]     dsum;
	logic [CW-1:0]   net;
	logic [15:0]     rx_inc;
	logic            rx_hit;
	logic [TW-1:0]   thr_ext, sh_ext, est_ext;
	logic            over;
	logic [PW-1:0]   acc;
	logic [FB-1:0]   est_new;
	logic            last_flow;
	logic [AW-1:0]   win_ext;
	logic [TW-1:0]   est_out_ext, sh_out_ext;

	always_comb begin
		ent      = rd_q;
		if (!rd_cv_q) begin
			ent.sent = '0;
			ent.link = '0;
			ent.pol  = '0;
		end
		if (!rd_sv_q) begin
			ent.win = '0;
			ent.est = '0;
		end
	end

	assign w_ext      = MW'(cfg.weight);
	assign one_ext    = MW'(1) << FB;
	assign beta_ext   = (w_ext > one_ext) ? one_ext : w_ext;
	assign beta       = beta_ext[FB:0];
	assign one_m_beta = one_ext[FB:0] - beta;

	assign s_inc   = sat_inc(ent.sent);
	assign dsum    = {1'b0, ent.link} + {1'b0, ent.pol};
	assign net     = ({1'b0, ent.sent} > dsum) ? ent.sent - CW'(dsum) : '0;
	assign rx_inc  = (&rx_q) ? rx_q : rx_q + 16'd1;
	assign rx_hit  = (cfg.loss_win != 16'd0) && (rx_inc >= cfg.loss_win);
	assign thr_ext = TW'(cfg.threshold);
	assign sh_ext  = TW'(shared_q);
	assign est_ext = TW'(ent.est);
	assign over    = cfg.early_en && (s_inc > ent.win) &&
	                 ((sh_ext > thr_ext) || (est_ext > thr_ext));

	always_comb begin
		acc = prod_a_q;
		if (ent.sent > CW'(plcr_pkg::MIN_SAMPLES))
			acc = prod_a_q + PW'(one_m_beta * rate_q);
		est_new = (|acc[PW-1:2*FB]) ? '1 : acc[2*FB-1:FB];
	end

	assign last_flow = (i_q + 7'd1 == cfg.n_use);
	assign out_free  = !out_valid || out_ready;
	assign pop       = (state_q == S_IDLE) && head_vld && out_free;

	// sequencer datapath controls
	always_comb begin
		rd_en     = 1'b0;
		rd_addr   = head.flow[FW-1:0];
		wr_en     = 1'b0;
		wr_addr   = cur_q.flow[FW-1:0];
		wr_data   = ent;
		cnt_clr   = 1'b0;
		div_start = 1'b0;
		div_num   = {drops_q, {FB{1'b0}}};
		div_den   = DW'(cfg.loss_win);
		out_ld    = 1'b0;
		o_flow    = cur_q.flow;
		o_drop    = 1'b0;
		o_win     = ent.win;
		o_est     = ent.est;
		o_last    = 1'b1;
		case (state_q)
			S_IDLE: begin
				if (pop) begin
					case (head.kind)
						plcr_pkg::K_TX_CHECK: begin
							rd_en = head.ok;
							if (!head.ok) begin
								out_ld = 1'b1;
								o_flow = head.flow;
								o_win  = '0;
								o_est  = '0;
							end
						end
						plcr_pkg::K_TX_COUNT, plcr_pkg::K_LINK_DROP: rd_en = head.ok;
						plcr_pkg::K_RX: div_start = head.ok && rx_hit;
						default: ;
					endcase
				end
			end
			S_PKT: begin
				wr_en = 1'b1;
				case (cur_q.kind)
					plcr_pkg::K_TX_CHECK: begin
						wr_data.sent = s_inc;
						if (over) wr_data.pol = sat_inc(ent.pol);
						out_ld = 1'b1;
						o_drop = over;
					end
					plcr_pkg::K_TX_COUNT: wr_data.sent = s_inc;
					default: wr_data.link = sat_inc(ent.link);
				endcase
			end
			S_T1RD, S_T2RD: begin
				rd_en   = 1'b1;
				rd_addr = i_q[FW-1:0];
			end
			S_T1CALC: begin
				div_start = (ent.sent != '0);
				div_num   = {ent.link, {FB{1'b0}}};
				div_den   = DW'(ent.sent);
			end
			S_T1ACC: begin
				wr_en       = 1'b1;
				wr_addr     = i_q[FW-1:0];
				wr_data.est = est_new;
				if (last_flow && cfg.mode == plcr_pkg::MODE_EQUAL) begin
					div_start = 1'b1;
					div_num   = NW'(cap_q);
					div_den   = DW'(cfg.n_use);
				end
			end
			S_T2OUT: begin
				if (out_free) begin
					wr_en   = 1'b1;
					wr_addr = i_q[FW-1:0];
					case (cfg.mode)
						plcr_pkg::MODE_NATURAL: wr_data.win = net;
						plcr_pkg::MODE_EQUAL:   wr_data.win = eq_q;
						default:                wr_data.win = ent.win;
					endcase
					out_ld  = 1'b1;
					o_flow  = i_q[5:0];
					o_win   = wr_data.win;
					o_last  = last_flow;
					cnt_clr = last_flow;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			i_q      <= '0;
			rx_q     <= '0;
			drops_q  <= '0;
			shared_q <= '0;
			cap_q    <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (pop) begin
						case (head.kind)
							plcr_pkg::K_TX_CHECK, plcr_pkg::K_TX_COUNT: begin
								if (head.ok) state_q <= S_PKT;
							end
							plcr_pkg::K_LINK_DROP: begin
								if (head.ok) begin
									state_q <= S_PKT;
									drops_q <= sat_inc(drops_q);
								end
							end
							plcr_pkg::K_RX: begin
								if (head.ok) begin
									rx_q <= rx_inc;
									if (rx_hit) state_q <= S_RXDIV;
								end
							end
							plcr_pkg::K_TICK: begin
								i_q     <= '0;
								cap_q   <= '0;
								state_q <= S_T1RD;
							end
							default: ;
						endcase
					end
				end
				S_PKT:    state_q <= S_IDLE;
				S_T1RD:   state_q <= S_T1CALC;
				S_T1CALC: begin
					cap_q   <= cap_q + CAPW'(net);
					state_q <= (ent.sent != '0) ? S_T1WAIT : S_T1MUL;
				end
				S_T1WAIT: if (div_done) state_q <= S_T1MUL;
				S_T1MUL:  state_q <= S_T1ACC;
				S_T1ACC: begin
					if (last_flow) begin
						i_q     <= '0;
						state_q <= (cfg.mode == plcr_pkg::MODE_EQUAL) ? S_EQWAIT : S_T2RD;
					end else begin
						i_q     <= i_q + 7'd1;
						state_q <= S_T1RD;
					end
				end
				S_EQWAIT: if (div_done) state_q <= S_T2RD;
				S_T2RD:   state_q <= S_T2OUT;
				S_T2OUT: begin
					if (out_free) begin
						// back to flow 0 so the index stays in range while idle
						i_q     <= last_flow ? 7'd0 : i_q + 7'd1;
						state_q <= last_flow ? S_IDLE : S_T2RD;
					end
				end
				S_RXDIV: begin
					if (div_done) begin
						shared_q <= (|div_quo[NW-1:FB]) ? '1 : div_quo[FB-1:0];
						rx_q     <= '0;
						drops_q  <= '0;
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload registers of the sequencer
	always_ff @(posedge clk) begin
		if (pop) cur_q <= head;
		case (state_q)
			S_T1CALC: rate_q <= '0;
			S_T1WAIT: if (div_done) rate_q <= (|div_quo[NW-1:FB]) ? '1 : div_quo[FB-1:0];
			S_T1MUL:  prod_a_q <= PW'(beta * ent.est);
			S_EQWAIT: if (div_done) eq_q <= (|div_quo[NW-1:CW]) ? '1 : div_quo[CW-1:0];
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (rd_en) rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_vld_q <= '0;
			st_vld_q  <= '0;
			rd_cv_q   <= 1'b0;
			rd_sv_q   <= 1'b0;
		end else begin
			if (rd_en) begin
				rd_cv_q <= cnt_vld_q[rd_addr];
				rd_sv_q <= st_vld_q[rd_addr];
			end
			if (wr_en) st_vld_q[wr_addr] <= 1'b1;
			if (cnt_clr) cnt_vld_q <= '0;
			else if (wr_en) cnt_vld_q[wr_addr] <= 1'b1;
		end
	end

	plcr_div #(.NW(NW), .DW(DW)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	// result register
	assign win_ext     = AW'(o_win);
	assign est_out_ext = TW'(o_est);
	assign sh_out_ext  = TW'(shared_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_ld) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ld) begin
			flow_id        <= o_flow;
			early_drop     <= o_drop;
			allowed_window <= win_ext[23:0];
			flow_loss      <= est_out_ext[15:0];
			shared_loss    <= sh_out_ext[15:0];
			last           <= o_last;
		end
	end

	`ASSERT_ALWAYS(a_state_onehot, $onehot(state_q), "sequencer state not one-hot")
	`ASSERT_IMP(a_idx_range, state_q != S_IDLE, i_q < cfg.n_use, "flow index out of range")
	`ASSERT_IMP(a_no_clobber, out_ld, out_free, "result overwritten before taken")

endmodule

/* sv/per_flow_loss_policer.sv */
// Per-flow loss policer: configuration registers, front end, queue and back end.
//
// Usage:
//  - Input channel (in_valid/in_ready, req_type, flow): one word per packet
//    event or tick. Transmit checks return one result word; a tick returns one
//    word per active flow in flow order, last set on the final one; other
//    events return nothing.
//  - Output channel (out_valid/out_ready): one result register. While the
//    receiver stalls the back end takes no new word; the front stage and the
//    two-word queue keep accepting input until they fill, then in_ready drops.
//  - Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is always
//    ready; write it only while the block is idle.
//  - An accepted transmit check for an active flow passes the front stage, the
//    queue, the state memory read register and the result register. The back end
//    handles a packet event in S_IDLE and S_PKT, a plain receive in S_IDLE alone.
//  - A receive closing a loss window runs the serial divider. A tick walks the
//    flow memory twice; per flow the loss-rate divide dominates, plus one more
//    divide in equal-share mode before the second walk returns the results.
//  - Reset clears configuration to defaults and all counters, windows and
//    estimates (per-entry valid bits, no clearing pass).
`include "assert_macros.svh"
module per_flow_loss_policer #(
	parameter int unsigned NUM_FLOWS   = 8,
	parameter int unsigned COUNT_WIDTH = 24,
	parameter int unsigned FRAC_BITS   = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  req_type,
	input  logic [5:0]  flow,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [5:0]  flow_id,
	output logic        early_drop,
	output logic [23:0] allowed_window,
	output logic [15:0] flow_loss,
	output logic [15:0] shared_loss,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	logic        en_q;
	logic [1:0]  mode_q;
	logic [15:0] wt_q, thr_q, lw_q;
	logic [6:0]  act_q;
	logic [6:0]  n_use;
	plcr_pkg::cfg_t cfg;

	logic            push, q_full, pop, head_vld;
	plcr_pkg::item_t push_item, head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q   <= 1'b0;
			mode_q <= 2'd0;
			wt_q   <= 16'd58982;
			thr_q  <= 16'd3277;
			lw_q   <= 16'd100;
			act_q  <= 7'd8;
		end else if (cfg_valid) begin
			case (cfg_index)
				plcr_pkg::CFG_EARLY_DROP: en_q   <= cfg_data[0];
				plcr_pkg::CFG_FAIRNESS:   mode_q <= cfg_data[1:0];
				plcr_pkg::CFG_EWMA:       wt_q   <= cfg_data;
				plcr_pkg::CFG_THRESHOLD:  thr_q  <= cfg_data;
				plcr_pkg::CFG_LOSS_WIN:   lw_q   <= cfg_data;
				plcr_pkg::CFG_ACTIVE:     act_q  <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// zero flows acts as one, too many acts as all
	assign n_use = (act_q == 7'd0) ? 7'd1 :
	               ({25'd0, act_q} > 32'(NUM_FLOWS)) ? 7'(NUM_FLOWS) : act_q;

	assign cfg.early_en  = en_q;
	assign cfg.mode      = mode_q;
	assign cfg.weight    = wt_q;
	assign cfg.threshold = thr_q;
	assign cfg.loss_win  = lw_q;
	assign cfg.n_use     = n_use;

	plcr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.req_type  (req_type),
		.flow      (flow),
		.n_use     (n_use),
		.push      (push),
		.push_item (push_item),
		.q_full    (q_full)
	);

	plcr_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.head_vld  (head_vld),
		.head      (head)
	);

	plcr_back #(
		.NUM_FLOWS   (NUM_FLOWS),
		.COUNT_WIDTH (COUNT_WIDTH),
		.FRAC_BITS   (FRAC_BITS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg),
		.head_vld       (head_vld),
		.head           (head),
		.pop            (pop),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.flow_id        (flow_id),
		.early_drop     (early_drop),
		.allowed_window (allowed_window),
		.flow_loss      (flow_loss),
		.shared_loss    (shared_loss),
		.last           (last)
	);

	`ASSERT_IMP(a_nuse_range, 1'b1, (n_use != 7'd0) && ({25'd0, n_use} <= 32'(NUM_FLOWS)),
		"active flow count out of range")

endmodule
